// File: rtl/core/rrd_pkg.sv
package rrd_pkg;

    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_BOTTOM_UP     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PITCH         = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_WIDTH    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_ADDRESS = 2'd3;

    localparam int LEN_W = 7;
    localparam int WIDTH_W = 16;

    localparam logic [WIDTH_W-1:0] RESET_PITCH      = 16'd320;
    localparam logic [WIDTH_W-1:0] RESET_LINE_WIDTH = 16'd320;

    typedef enum logic [3:0] {
        PH_START   = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_LITERAL = 4'b0100,
        PH_RUN     = 4'b1000
    } phase_t;

    typedef struct packed {
        phase_t           phase;
        logic [LEN_W-1:0] lit_rem;
        logic [LEN_W-1:0] run_len;
    } ctrl_t;

endpackage

// File: rtl/core/rrd_in_if.sv
interface rrd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       last_byte;

    modport source (output valid, output code_byte, output last_byte, input ready);
    modport sink (input valid, input code_byte, input last_byte, output ready);
endinterface

// File: rtl/core/rrd_out_if.sv
interface rrd_out_if #(
    parameter int ADDR_WIDTH = 24
);
    logic                  valid;
    logic                  ready;
    logic                  write_enable;
    logic [ADDR_WIDTH-1:0] write_address;
    logic [7:0]            write_value;
    logic [6:0]            write_count;
    logic [ADDR_WIDTH-1:0] total_written;
    logic                  stream_done;

    modport source (
        output valid, output write_enable, output write_address, output write_value,
        output write_count, output total_written, output stream_done, input ready
    );
    modport sink (
        input valid, input write_enable, input write_address, input write_value,
        input write_count, input total_written, input stream_done, output ready
    );
endinterface

// File: rtl/core/rrd_step.sv
module rrd_step #(
    parameter int ADDR_WIDTH = 24
) (
    input  rrd_pkg::ctrl_t                 ctrl,
    input  logic [ADDR_WIDTH-1:0]          ptr,
    input  logic [ADDR_WIDTH-1:0]          total,
    input  logic                           bottom_up,
    input  logic [rrd_pkg::WIDTH_W-1:0]    pitch,
    input  logic [rrd_pkg::WIDTH_W-1:0]    line_width,
    input  logic [ADDR_WIDTH-1:0]          start_address,
    input  logic [7:0]                     code_byte,
    input  logic                           last_byte,
    output rrd_pkg::ctrl_t                 ctrl_next,
    output logic [ADDR_WIDTH-1:0]          ptr_next,
    output logic [ADDR_WIDTH-1:0]          total_next,
    output logic                           res_we,
    output logic [ADDR_WIDTH-1:0]          res_addr,
    output logic [7:0]                     res_value,
    output logic [rrd_pkg::LEN_W-1:0]      res_count,
    output logic                           res_done
);
    import rrd_pkg::*;

    localparam int EXT_W = ADDR_WIDTH + WIDTH_W;

    phase_t                ph;
    logic [ADDR_WIDTH-1:0] base_ptr;
    logic [ADDR_WIDTH-1:0] base_total;
    logic [ADDR_WIDTH-1:0] one_ext;
    logic [ADDR_WIDTH-1:0] run_ext;
    logic [EXT_W-1:0]      ptr_ext;
    logic [EXT_W-1:0]      sw_ext;
    logic [EXT_W-1:0]      rw_ext;
    logic [EXT_W-1:0]      skip_sum;

    // The first byte of a stream reloads the pointer and clears the total.
    always_comb
    begin
        if (ctrl.phase == PH_START)
        begin
            ph         = PH_HEADER;
            base_ptr   = start_address;
            base_total = '0;
        end
        else
        begin
            ph         = ctrl.phase;
            base_ptr   = ptr;
            base_total = total;
        end
    end

    assign one_ext = {{(ADDR_WIDTH-1){1'b0}}, 1'b1};
    assign run_ext = {{(ADDR_WIDTH-LEN_W){1'b0}}, ctrl.run_len};
    assign ptr_ext = {{WIDTH_W{1'b0}}, base_ptr};
    assign sw_ext  = {{ADDR_WIDTH{1'b0}}, pitch};
    assign rw_ext  = {{ADDR_WIDTH{1'b0}}, line_width};
    assign skip_sum = bottom_up ? (ptr_ext - rw_ext - sw_ext) : (ptr_ext + sw_ext - rw_ext);

    always_comb
    begin
        ctrl_next  = ctrl;
        ctrl_next.phase = ph;
        ptr_next   = base_ptr;
        total_next = base_total;
        res_we     = 1'b0;
        res_addr   = '0;
        res_value  = '0;
        res_count  = '0;
        unique case (ph)
            PH_HEADER:
            begin
                if (code_byte[7])
                begin
                    ctrl_next.lit_rem = code_byte[LEN_W-1:0];
                    if (code_byte[LEN_W-1:0] != '0)
                    begin
                        ctrl_next.phase = PH_LITERAL;
                    end
                end
                else if (code_byte == 8'd0)
                begin
                    ptr_next = skip_sum[ADDR_WIDTH-1:0];
                end
                else
                begin
                    ctrl_next.run_len = code_byte[LEN_W-1:0];
                    ctrl_next.phase   = PH_RUN;
                end
            end
            PH_LITERAL:
            begin
                res_we            = 1'b1;
                res_addr          = base_ptr;
                res_value         = code_byte;
                res_count         = {{(LEN_W-1){1'b0}}, 1'b1};
                ptr_next          = base_ptr + one_ext;
                total_next        = base_total + one_ext;
                ctrl_next.lit_rem = ctrl.lit_rem - {{(LEN_W-1){1'b0}}, 1'b1};
                if (ctrl.lit_rem == {{(LEN_W-1){1'b0}}, 1'b1})
                begin
                    ctrl_next.phase = PH_HEADER;
                end
            end
            default:
            begin
                res_we            = 1'b1;
                res_addr          = base_ptr;
                res_value         = code_byte;
                res_count         = ctrl.run_len;
                ptr_next          = base_ptr + run_ext;
                total_next        = base_total + run_ext;
                ctrl_next.run_len = '0;
                ctrl_next.phase   = PH_HEADER;
            end
        endcase
        // A final byte drops any unfinished block and rearms the stream start.
        if (last_byte)
        begin
            ctrl_next.phase   = PH_START;
            ctrl_next.lit_rem = '0;
            ctrl_next.run_len = '0;
        end
    end

    assign res_done = last_byte;

endmodule

// File: rtl/core/row_rle_decoder.sv
// Channel   Direction  Payload
// in_chan   sink       code_byte[7:0], last_byte
// out_chan  source     write_enable, write_address, write_value, write_count,
//                      total_written, stream_done
//
// One request is accepted every cycle while the result register is free or being taken; its result is registered there.
// Throughput is set by the single decode stage between the input and result registers.
// Reset clears the handshake registers and the decoder phase and returns the
// configuration registers to their reset values.
// A stalled result holds in its register while one more request waits in the input register.
module row_rle_decoder #(
    parameter int ADDR_WIDTH = 24,
    localparam int CFG_DATA_W = (ADDR_WIDTH > 16) ? ADDR_WIDTH : 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_enable,
    input  logic [rrd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]            cfg_data,
    rrd_in_if.sink                           in_chan,
    rrd_out_if.source                        out_chan
);
    import rrd_pkg::*;

    logic                  bottom_up_reg;
    logic [WIDTH_W-1:0]    pitch_reg;
    logic [WIDTH_W-1:0]    line_width_reg;
    logic [ADDR_WIDTH-1:0] start_address_reg;

    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [7:0]            in_byte_reg;
    logic                  in_last_reg;

    ctrl_t                 ctrl_reg;
    ctrl_t                 ctrl_next;
    logic [ADDR_WIDTH-1:0] ptr_reg;
    logic [ADDR_WIDTH-1:0] ptr_next;
    logic [ADDR_WIDTH-1:0] total_reg;
    logic [ADDR_WIDTH-1:0] total_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_we_reg;
    logic [ADDR_WIDTH-1:0] out_addr_reg;
    logic [7:0]            out_value_reg;
    logic [LEN_W-1:0]      out_count_reg;
    logic [ADDR_WIDTH-1:0] out_total_reg;
    logic                  out_done_reg;

    logic                  res_we;
    logic [ADDR_WIDTH-1:0] res_addr;
    logic [7:0]            res_value;
    logic [LEN_W-1:0]      res_count;
    logic                  res_done;

    logic                  advance;
    logic                  in_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bottom_up_reg     <= 1'b0;
            pitch_reg         <= RESET_PITCH;
            line_width_reg    <= RESET_LINE_WIDTH;
            start_address_reg <= '0;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                CFG_BOTTOM_UP:     bottom_up_reg     <= cfg_data[0];
                CFG_PITCH:         pitch_reg         <= cfg_data[WIDTH_W-1:0];
                CFG_LINE_WIDTH:    line_width_reg    <= cfg_data[WIDTH_W-1:0];
                CFG_START_ADDRESS: start_address_reg <= cfg_data[ADDR_WIDTH-1:0];
                default:           bottom_up_reg     <= bottom_up_reg;
            endcase
        end
    end

    assign advance        = in_valid_reg && (!out_valid_reg || out_chan.ready);
    assign in_chan.ready  = !in_valid_reg || advance;
    assign in_take        = in_chan.valid && in_chan.ready;
    assign in_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctrl_reg      <= '{phase: PH_START, lit_rem: '0, run_len: '0};
            ptr_reg       <= '0;
            total_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                ctrl_reg  <= ctrl_next;
                ptr_reg   <= ptr_next;
                total_reg <= total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= in_chan.code_byte;
            in_last_reg <= in_chan.last_byte;
        end
        if (advance)
        begin
            out_we_reg    <= res_we;
            out_addr_reg  <= res_addr;
            out_value_reg <= res_value;
            out_count_reg <= res_count;
            out_total_reg <= total_next;
            out_done_reg  <= res_done;
        end
    end

    rrd_step #(
        .ADDR_WIDTH(ADDR_WIDTH)
    ) u_step (
        .ctrl          (ctrl_reg),
        .ptr           (ptr_reg),
        .total         (total_reg),
        .bottom_up     (bottom_up_reg),
        .pitch         (pitch_reg),
        .line_width    (line_width_reg),
        .start_address (start_address_reg),
        .code_byte     (in_byte_reg),
        .last_byte     (in_last_reg),
        .ctrl_next     (ctrl_next),
        .ptr_next      (ptr_next),
        .total_next    (total_next),
        .res_we        (res_we),
        .res_addr      (res_addr),
        .res_value     (res_value),
        .res_count     (res_count),
        .res_done      (res_done)
    );

    assign out_chan.valid         = out_valid_reg;
    assign out_chan.write_enable  = out_we_reg;
    assign out_chan.write_address = out_addr_reg;
    assign out_chan.write_value   = out_value_reg;
    assign out_chan.write_count   = out_count_reg;
    assign out_chan.total_written = out_total_reg;
    assign out_chan.stream_done   = out_done_reg;

    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_we_reg) |->
            (out_addr_reg == '0 && out_value_reg == '0 && out_count_reg == '0))
        else $error("result without a write carries nonzero fields");

    a_literal_len: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_reg.phase == PH_LITERAL) |-> (ctrl_reg.lit_rem != '0))
        else $error("literal phase with no bytes remaining");

    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_reg.phase == PH_RUN) |-> (ctrl_reg.run_len != '0))
        else $error("run phase with zero run length");

    a_done_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_done_reg) |-> (ctrl_reg.phase == PH_START))
        else $error("stream end did not rearm the stream start");

endmodule

// File: test/row_rle_decoder_tb.sv
`timescale 1ns / 100ps

module row_rle_decoder_tb;
    import rrd_pkg::*;

    localparam int ADDR_W = 24;
    localparam int ITEMS_PER_PHASE = 240;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_SLACK = 4;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic              write_enable;
        logic [ADDR_W-1:0] write_address;
        logic [7:0]        write_value;
        logic [6:0]        write_count;
        logic [ADDR_W-1:0] total_written;
        logic              stream_done;
    } write_cmd_t;

    typedef struct packed {
        logic              bottom_up;
        logic [15:0]       pitch;
        logic [15:0]       line_width;
        logic [ADDR_W-1:0] start_address;
    } surface_cfg_t;

    class write_scoreboard;
        logic              bottom_up;
        logic [15:0]       pitch;
        logic [15:0]       line_width;
        logic [ADDR_W-1:0] start_address;
        phase_t            phase;
        logic [LEN_W-1:0]  literal_left;
        logic [LEN_W-1:0]  run_cnt;
        logic [ADDR_W-1:0] write_ptr;
        logic [ADDR_W-1:0] byte_total;
        write_cmd_t        expected_writes[$];
        int                mismatch_count;

        function new();
            apply_reset();
            mismatch_count = 0;
        endfunction

        function void apply_reset();
            bottom_up = 1'b0;
            pitch = RESET_PITCH;
            line_width = RESET_LINE_WIDTH;
            start_address = '0;
            phase = PH_START;
            literal_left = '0;
            run_cnt = '0;
            write_ptr = '0;
            byte_total = '0;
            expected_writes.delete();
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] index, logic [ADDR_W-1:0] value);
            case (index)
                CFG_BOTTOM_UP:     bottom_up = value[0];
                CFG_PITCH:         pitch = value[15:0];
                CFG_LINE_WIDTH:    line_width = value[15:0];
                CFG_START_ADDRESS: start_address = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_writes.size();
        endfunction

        // Decodes one accepted request into the write command it must produce.
        function void note_request(logic [7:0] value, logic last);
            write_cmd_t cmd;
            cmd = '0;
            if (phase == PH_START)
            begin
                write_ptr = start_address;
                byte_total = '0;
                phase = PH_HEADER;
            end
            case (phase)
                PH_HEADER:
                begin
                    if (value[7])
                    begin
                        literal_left = value[6:0];
                        if (literal_left != 0)
                            phase = PH_LITERAL;
                    end
                    else if (value == 8'h00)
                    begin
                        if (bottom_up)
                            write_ptr = write_ptr - line_width - pitch;
                        else
                            write_ptr = write_ptr + pitch - line_width;
                    end
                    else
                    begin
                        run_cnt = value[6:0];
                        phase = PH_RUN;
                    end
                end
                PH_LITERAL:
                begin
                    cmd.write_enable = 1'b1;
                    cmd.write_address = write_ptr;
                    cmd.write_value = value;
                    cmd.write_count = 7'd1;
                    write_ptr = write_ptr + 1'b1;
                    byte_total = byte_total + 1'b1;
                    literal_left = literal_left - 1'b1;
                    if (literal_left == 0)
                        phase = PH_HEADER;
                end
                PH_RUN:
                begin
                    cmd.write_enable = 1'b1;
                    cmd.write_address = write_ptr;
                    cmd.write_value = value;
                    cmd.write_count = run_cnt;
                    write_ptr = write_ptr + run_cnt;
                    byte_total = byte_total + run_cnt;
                    run_cnt = '0;
                    phase = PH_HEADER;
                end
                default: ;
            endcase
            cmd.total_written = byte_total;
            cmd.stream_done = last;
            if (last)
            begin
                phase = PH_START;
                literal_left = '0;
                run_cnt = '0;
            end
            expected_writes.push_back(cmd);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, got %0h", field, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_result(write_cmd_t got);
            write_cmd_t want;
            if (expected_writes.size() == 0)
            begin
                $error("write command with no request pending: %h", got);
                mismatch_count++;
                return;
            end
            want = expected_writes.pop_front();
            compare_field("write_enable", want.write_enable, got.write_enable);
            compare_field("write_address", want.write_address, got.write_address);
            compare_field("write_value", want.write_value, got.write_value);
            compare_field("write_count", want.write_count, got.write_count);
            compare_field("total_written", want.total_written, got.total_written);
            compare_field("stream_done", want.stream_done, got.stream_done);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write_enable;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [ADDR_W-1:0] cfg_data;

    rrd_in_if in_chan ();
    rrd_out_if #(.ADDR_WIDTH(ADDR_W)) out_chan ();

    row_rle_decoder #(.ADDR_WIDTH(ADDR_W)) uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_chan          (in_chan),
        .out_chan         (out_chan)
    );

    write_scoreboard sb;
    int cycle_count = 0;
    int requests_sent = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic hold_off_pending = 1'b0;
    int hold_left = 0;

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("row_rle_decoder test failed");
            $finish;
        end
        else
        begin
            if (rst_n && out_chan.valid && out_chan.ready)
                sb.check_result({out_chan.write_enable, out_chan.write_address,
                                 out_chan.write_value, out_chan.write_count,
                                 out_chan.total_written, out_chan.stream_done});
            if (rst_n && in_chan.valid && in_chan.ready)
                sb.note_request(in_chan.code_byte, in_chan.last_byte);
        end
    end

    // The receiver either stalls at random or sits out a long hold-off.
    always @(posedge clk)
    begin
        if (hold_off_pending)
        begin
            hold_off_pending <= 1'b0;
            hold_left <= HOLD_OFF_CYCLES;
            out_chan.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_chan.ready <= 1'b0;
        end
        else
            out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_byte(input logic [7:0] value, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_chan.valid <= 1'b0;
            @(posedge clk);
        end
        in_chan.valid <= 1'b1;
        in_chan.code_byte <= value;
        in_chan.last_byte <= last;
        @(posedge clk);
        while (!in_chan.ready)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic wait_for_drain();
        in_chan.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [ADDR_W-1:0] value);
        cfg_write_enable <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        sb.write_register(index, value);
        @(posedge clk);
    endtask

    task automatic apply_surface_cfg(input surface_cfg_t cfg);
        write_reg(CFG_BOTTOM_UP, ADDR_W'(cfg.bottom_up));
        write_reg(CFG_PITCH, ADDR_W'(cfg.pitch));
        write_reg(CFG_LINE_WIDTH, ADDR_W'(cfg.line_width));
        write_reg(CFG_START_ADDRESS, cfg.start_address);
        cfg_write_enable <= 1'b0;
    endtask

    // A stream of literal blocks, runs and row skips, now and then cut short.
    task automatic send_random_stream();
        logic [7:0] stream_bytes[$];
        logic [6:0] len;
        int segments;
        int kind;
        int cut;
        int s;
        int i;
        segments = $urandom_range(1, 8);
        for (s = 0; s < segments; s++)
        begin
            kind = $urandom_range(9);
            if (kind < 4)
            begin
                len = ($urandom_range(24) == 0) ? 7'($urandom_range(127)) :
                                                  7'($urandom_range(12));
                stream_bytes.push_back({1'b1, len});
                repeat (len) stream_bytes.push_back(8'($urandom));
            end
            else if (kind < 8)
            begin
                len = 7'($urandom_range(1, 127));
                stream_bytes.push_back({1'b0, len});
                stream_bytes.push_back(8'($urandom));
            end
            else
                stream_bytes.push_back(8'h00);
        end
        if ($urandom_range(7) == 0)
        begin
            cut = $urandom_range(1, stream_bytes.size());
            while (stream_bytes.size() > cut)
                void'(stream_bytes.pop_back());
        end
        for (i = 0; i < stream_bytes.size(); i++)
            send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
    endtask

    initial
    begin
        surface_cfg_t plans[6];
        int p;
        int phase_end;
        bit paused;

        plans[0] = '{1'b0, 16'd640, 16'd320, 24'h001000};
        plans[1] = '{1'b1, 16'hFFFF, 16'hFFFF, 24'hFFFFFF};
        plans[2] = '{1'b0, 16'd1, 16'd0, 24'h000000};
        plans[3] = '{1'b1, 16'd1, 16'd0, 24'($urandom)};
        plans[4] = '{1'($urandom), 16'($urandom_range(1, 65535)), 16'($urandom),
                     24'($urandom)};
        plans[5] = '{1'b0, 16'hFFFF, 16'd0, 24'hFFFFF0};

        sb = new();
        rst_n = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_chan.valid = 1'b0;
        in_chan.code_byte = '0;
        in_chan.last_byte = 1'b0;
        out_chan.ready = 1'b0;
        send_idle_pct = 14;
        recv_idle_pct <= 64;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty literal, row skip, literals, longest and shortest runs,
        // truncated literal and run, and single-byte streams.
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h83, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h85, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b1);
        send_byte(8'h05, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'h80, 1'b1);
        send_byte(8'hAB, 1'b1);
        send_byte(8'h02, 1'b0);
        send_byte(8'hA5, 1'b1);

        for (p = 0; p < 6; p++)
        begin
            wait_for_drain();
            if (p == 2)
            begin
                send_idle_pct = 64;
                recv_idle_pct <= 14;
            end
            else if (p == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            apply_surface_cfg(plans[p]);
            phase_end = requests_sent + ITEMS_PER_PHASE;
            paused = 1'b0;
            while (requests_sent < phase_end)
            begin
                if (!paused && requests_sent >= phase_end - ITEMS_PER_PHASE / 2)
                begin
                    paused = 1'b1;
                    if (p == 3)
                        wait_for_drain();
                    else if (p == 5)
                        hold_off_pending <= 1'b1;
                end
                if ($urandom_range(99) < 8)
                    send_byte(8'($urandom), $urandom_range(7) == 0);
                else
                    send_random_stream();
            end
        end

        wait_for_drain();
        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("row_rle_decoder test passed");
        else
            $display("row_rle_decoder test failed");
        $finish;
    end

endmodule
